[src/slot_pool_allocator_macros.svh]
// Assertion macros for the slot pool allocator checker.
// Needs a clk and an rst_n in the scope where a macro is used.
`ifndef SLOT_POOL_ALLOCATOR_MACROS_SVH
`define SLOT_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define SPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot pool allocator: assertion failed");

// Next-cycle implication, disabled while reset is held
`define SPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot pool allocator: assertion failed");

`endif

[src/spa_pkg.sv]
// Shared types, constants and helpers for the slot pool allocator.
// No dependencies; used by every module of the block.
package spa_pkg;

  // Pool geometry
  localparam int POOL_SLOTS = 256;
  localparam int ADDR_W     = $clog2(POOL_SLOTS);
  localparam int SLOT_W     = 9;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [ADDR_W-1:0] slot_idx_t;

  // Slot code meaning "no slot"
  localparam slot_t SLOT_NONE = SLOT_W'(POOL_SLOTS);

  // Request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_LINK  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    slot_t      slot;
  } spa_in_t;

  typedef struct packed {
    slot_t      slot_out;
    logic [1:0] status;
  } spa_out_t;

  // Idle-list link of a slot that has not been written since reset:
  // the next index, and "none" past the last slot.
  function automatic slot_t reset_next(input slot_idx_t idx);
    return SLOT_W'(idx) + SLOT_W'(1);
  endfunction

endpackage

[src/spa_link_ram.sv]
// Link memory: one write port, one registered read port, write-first.
// Depends on spa_pkg for default sizes.
module spa_link_ram
  import spa_pkg::*;
#(
  parameter int DEPTH = POOL_SLOTS,
  parameter int DW    = SLOT_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port, and a read that sees a write to the same entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/slot_pool_allocator.sv]
// Slot pool allocator: an idle slot list and a doubly linked active slot list.
// A request and its link RAM reads are registered at accept; the commit stage
// then loads the result register when the output register is free or drains.
// Throughput: one request per cycle unless the output stalls; the link RAM reads
// feed a single commit stage that writes each RAM at most once and updates heads.
// Reset (rst_n, synchronous, active low) restores the initial lists at once: a
// fill count marks the slots never handed out, whose idle links and active marks
// read as the reset chain; no clearing pass, requests are taken right away.
module slot_pool_allocator
  import spa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  spa_in_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output spa_out_t out_rsp
);

  // Idle-list links (inext), active-list links (anext) and active back links (prev)
  // live in three RAMs, the active marks in a fourth. The idle list is only ever
  // popped at its head, so it needs no back links; the prev entry of the active
  // head is never used. The idle list is always a stack of freed slots on top of
  // the untouched chain fill_r..POOL_SLOTS-1.

  logic      s1_valid_r;
  spa_in_t   s1_req_r;
  slot_idx_t s1_inext_addr_r;
  logic      out_valid_r;
  spa_out_t  out_rsp_r;
  slot_t     idle_head_r;
  slot_t     active_head_r;
  slot_t     fill_r;

  logic      s1_adv;
  logic      in_acc;

  // RAM ports
  logic      inext_we, anext_we, prev_we;
  slot_idx_t inext_waddr, anext_waddr, prev_waddr;
  slot_t     inext_wdata, anext_wdata, prev_wdata;
  slot_idx_t inext_raddr, link_raddr;
  slot_t     inext_rdata, anext_rdata, prev_rdata;
  logic      act_rdata;

  // Commit stage results
  spa_out_t  rsp;
  slot_t     idle_head_nxt;
  slot_t     active_head_nxt;
  slot_t     fill_nxt;
  slot_t     idle_head_eff;
  logic      act_set, act_clr;
  slot_idx_t act_idx;
  slot_t     inext_val;

  // Handshake: the commit stage moves when the output register is free or drains
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Read addresses: an allocate reads the link of the idle head as it stands
  // after the request now committing
  assign idle_head_eff = s1_adv ? idle_head_nxt : idle_head_r;
  assign inext_raddr   = (in_req.req_type == REQ_ALLOC) ? idle_head_eff[ADDR_W-1:0]
                                                        : in_req.slot[ADDR_W-1:0];
  assign link_raddr    = in_req.slot[ADDR_W-1:0];

  spa_link_ram u_inext (
    .clk   (clk),
    .we    (inext_we && s1_adv),
    .waddr (inext_waddr),
    .wdata (inext_wdata),
    .re    (in_acc),
    .raddr (inext_raddr),
    .rdata (inext_rdata)
  );

  spa_link_ram u_anext (
    .clk   (clk),
    .we    (anext_we && s1_adv),
    .waddr (anext_waddr),
    .wdata (anext_wdata),
    .re    (in_acc),
    .raddr (link_raddr),
    .rdata (anext_rdata)
  );

  spa_link_ram u_prev (
    .clk   (clk),
    .we    (prev_we && s1_adv),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (in_acc),
    .raddr (link_raddr),
    .rdata (prev_rdata)
  );

  // Active marks; only meaningful below the fill count
  spa_link_ram #(
    .DEPTH (POOL_SLOTS),
    .DW    (1)
  ) u_act (
    .clk   (clk),
    .we    ((act_set || act_clr) && s1_adv),
    .waddr (act_idx),
    .wdata (act_set),
    .re    (in_acc),
    .raddr (link_raddr),
    .rdata (act_rdata)
  );

  // Idle link of the addressed slot; slots never handed out keep the reset chain
  assign inext_val = (SLOT_W'(s1_inext_addr_r) < fill_r) ? inext_rdata
                                                         : reset_next(s1_inext_addr_r);

  // Commit stage: decode the request, pick the result and the list updates
  always_comb begin
    slot_idx_t s_idx;
    logic      s_in_range;
    logic      s_active;
    slot_t     before_slot;
    slot_t     after_slot;

    s_idx       = s1_req_r.slot[ADDR_W-1:0];
    s_in_range  = s1_req_r.slot < SLOT_NONE;
    s_active    = s_in_range && (s1_req_r.slot < fill_r) && act_rdata;
    before_slot = prev_rdata;
    after_slot  = anext_rdata;

    rsp.slot_out    = SLOT_NONE;
    rsp.status      = ST_BAD;
    idle_head_nxt   = idle_head_r;
    active_head_nxt = active_head_r;
    fill_nxt        = fill_r;
    inext_we        = 1'b0;
    inext_waddr     = s_idx;
    inext_wdata     = idle_head_r;
    anext_we        = 1'b0;
    anext_waddr     = s_idx;
    anext_wdata     = active_head_r;
    prev_we         = 1'b0;
    prev_waddr      = s_idx;
    prev_wdata      = before_slot;
    act_set         = 1'b0;
    act_clr         = 1'b0;
    act_idx         = s_idx;

    case (s1_req_r.req_type)
      REQ_ALLOC: begin
        if (idle_head_r < SLOT_NONE) begin
          // pop the idle head, push it on the active list
          rsp.slot_out    = idle_head_r;
          rsp.status      = ST_OK;
          idle_head_nxt   = inext_val;
          active_head_nxt = idle_head_r;
          anext_we        = 1'b1;
          anext_waddr     = idle_head_r[ADDR_W-1:0];
          anext_wdata     = active_head_r;
          prev_we         = active_head_r < SLOT_NONE;
          prev_waddr      = active_head_r[ADDR_W-1:0];
          prev_wdata      = idle_head_r;
          act_set         = 1'b1;
          act_idx         = idle_head_r[ADDR_W-1:0];
          // first hand-out of the untouched chain head
          if (idle_head_r == fill_r) begin
            fill_nxt = fill_r + SLOT_W'(1);
          end
        end else begin
          rsp.status = ST_EMPTY;
        end
      end
      REQ_FREE: begin
        if (s_active) begin
          // unlink from the active list, push on the idle list
          rsp.slot_out = s1_req_r.slot;
          rsp.status   = ST_OK;
          if (active_head_r == s1_req_r.slot) begin
            active_head_nxt = after_slot;
          end else begin
            anext_we    = 1'b1;
            anext_waddr = before_slot[ADDR_W-1:0];
            anext_wdata = after_slot;
          end
          prev_we       = after_slot < SLOT_NONE;
          prev_waddr    = after_slot[ADDR_W-1:0];
          prev_wdata    = before_slot;
          inext_we      = 1'b1;
          inext_waddr   = s_idx;
          inext_wdata   = idle_head_r;
          idle_head_nxt = s1_req_r.slot;
          act_clr       = 1'b1;
        end
      end
      REQ_LINK: begin
        if (s1_req_r.slot == SLOT_NONE) begin
          rsp.slot_out = active_head_r;
          rsp.status   = ST_OK;
        end else if (s_in_range) begin
          rsp.slot_out = s_active ? anext_rdata : inext_val;
          rsp.status   = ST_OK;
        end
      end
      default: begin
        rsp.status = ST_BAD;
      end
    endcase
  end

  // Request register and read address of the idle-link RAM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_acc) begin
      s1_req_r        <= in_req;
      s1_inext_addr_r <= inext_raddr;
    end
  end

  // List heads and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_head_r   <= '0;
      active_head_r <= SLOT_NONE;
      fill_r        <= '0;
    end else if (s1_adv) begin
      idle_head_r   <= idle_head_nxt;
      active_head_r <= active_head_nxt;
      fill_r        <= fill_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

[src/spa_checker.sv]
// Port-level checks for the slot pool allocator, bound to the top level.
// Depends on spa_pkg and slot_pool_allocator_macros.svh.
`include "slot_pool_allocator_macros.svh"

module spa_checker
  import spa_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input spa_in_t  in_req,
  input logic     out_valid,
  input logic     out_ready,
  input spa_out_t out_rsp
);

  // A stalled result holds
  `SPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rsp))

  // Failed requests never carry a slot
  `SPA_ASSERT_NOW(a_empty_none, out_valid && (out_rsp.status == ST_EMPTY), out_rsp.slot_out == SLOT_NONE)
  `SPA_ASSERT_NOW(a_bad_none, out_valid && (out_rsp.status == ST_BAD), out_rsp.slot_out == SLOT_NONE)

  // A result appearing on an idle output follows an accepted request, through the request register
  `SPA_ASSERT_NOW(a_result_cause, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind slot_pool_allocator spa_checker u_spa_checker (.*);
